>>> design/bbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and codes of the block buffer cache tag and policy engine.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int BBC_ENTRIES  = 16;
   localparam int BBC_REF_BITS = 8;

   // slot status
   localparam logic [1:0] ST_INVALID = 2'd0;
   localparam logic [1:0] ST_VALID   = 2'd1;
   localparam logic [1:0] ST_DIRTY   = 2'd2;

   // actions
   localparam logic [2:0] ACT_GET     = 3'd0;
   localparam logic [2:0] ACT_READ    = 3'd1;
   localparam logic [2:0] ACT_RELEASE = 3'd2;
   localparam logic [2:0] ACT_MARK    = 3'd3;
   localparam logic [2:0] ACT_IODONE  = 3'd4;
   localparam logic [2:0] ACT_SYNC    = 3'd5;

   // result kinds
   localparam logic [2:0] K_ACQUIRED = 3'd0;
   localparam logic [2:0] K_WRITE    = 3'd1;
   localparam logic [2:0] IO_READ    = 3'd2;
   localparam logic [2:0] K_NOFREE   = 3'd3;
   localparam logic [2:0] K_DONE     = 3'd4;
   localparam logic [2:0] K_ERROR    = 3'd5;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] device;
      logic [31:0] block;
      logic [3:0]  entry;
      logic [1:0]  io_status;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  entry_res;
      logic [15:0] device_res;
      logic [31:0] block_res;
      logic        hit;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

>>> design/block_buffer_cache_lru_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_top
// Tag and LRU replacement engine of a disk block buffer cache. Slot records
// and LRU order live in two RAMs and are walked by a sequencer.
// ----------------------------------------------------------------------------
// Release, mark dirty, io done: read in S_EN_RD, result registered in S_EN_EVAL.
// Get/read hit: lookup (S_LK_*), LRU position find (S_PF_*), then LRU shift (S_SH_*).
// Miss: lookup, then S_WK_RD, S_WK_SLOT, S_WK_EVAL per LRU position (record RAM read
// follows the LRU RAM read), then the shift; sync walks with no lookup or shift.
// One item at a time. Reset: a clearing pass fills both RAMs; req_stall is high.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_top #(
   parameter int ENTRIES  = bbc_pkg::BBC_ENTRIES,
   parameter int REF_BITS = bbc_pkg::BBC_REF_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bbc_pkg::req_type req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bbc_pkg::rsp_type      rsp_word
);
   import bbc_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int RW = REF_BITS + 51;
   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
   localparam int ST_LO  = REF_BITS + 1;
   localparam int BLK_LO = REF_BITS + 3;
   localparam int DEV_LO = REF_BITS + 35;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_LK_RD, S_LK_CMP, S_PF_RD, S_PF_CMP, S_SH_RD, S_SH_WR,
      S_SH_LAST, S_ACQ, S_RDREQ, S_WK_RD, S_WK_SLOT, S_WK_EVAL, S_EN_RD,
      S_EN_EVAL, S_ONE
   } state_type;

   function automatic logic [RW-1:0] pack_rec(input logic [15:0] dev,
         input logic [31:0] blk, input logic [1:0] st,
         input logic [REF_BITS-1:0] refs, input logic busy);
      return {dev, blk, st, refs, busy};
   endfunction

   function automatic logic [REF_BITS-1:0] inc(input logic [REF_BITS-1:0] r);
      return (r == REF_MAX) ? r : r + REF_BITS'(1);
   endfunction

   function automatic logic [3:0] to_ent(input logic [IW-1:0] idx);
      logic [IW+3:0] t;
      t = {4'b0, idx};
      return t[3:0];
   endfunction

   function automatic logic [IW-1:0] to_idx(input logic [3:0] e);
      logic [IW+3:0] t;
      t = {{IW{1'b0}}, e};
      return t[IW-1:0];
   endfunction

   state_type     state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in, p_ff, p_in, s_ff, s_in;
   req_type       req_ff, req_in;
   logic [RW-1:0] rec_ff, rec_in;
   logic          hit_ff, hit_in;
   rsp_type       one_ff, one_in;
   logic          rsp_vld_ff;
   rsp_type       rsp_ff;

   logic          rec_we, lru_we;
   logic [IW-1:0] rec_waddr, rec_raddr, lru_waddr, lru_raddr, lru_wdata, lru_rdata;
   logic [RW-1:0] rec_wdata, rec_rdata;
   logic          emit;
   rsp_type       emit_word;

   logic [15:0]         r_dev, f_dev;
   logic [31:0]         r_blk, f_blk;
   logic [1:0]          r_st, f_st;
   logic [REF_BITS-1:0] r_refs, f_refs;
   logic                r_busy, f_busy;
   logic                out_free, is_sync, needrd;

   assign r_dev  = rec_rdata[DEV_LO +: 16];
   assign r_blk  = rec_rdata[BLK_LO +: 32];
   assign r_st   = rec_rdata[ST_LO +: 2];
   assign r_refs = rec_rdata[REF_BITS:1];
   assign r_busy = rec_rdata[0];
   assign f_dev  = rec_ff[DEV_LO +: 16];
   assign f_blk  = rec_ff[BLK_LO +: 32];
   assign f_st   = rec_ff[ST_LO +: 2];
   assign f_refs = rec_ff[REF_BITS:1];
   assign f_busy = rec_ff[0];

   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign is_sync  = (req_ff.action == ACT_SYNC);
   assign needrd   = (req_ff.action == ACT_READ) && (f_st == ST_INVALID) && !f_busy;

   always_comb begin
      logic adv;
      adv       = 1'b0;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      p_in      = p_ff;
      s_in      = s_ff;
      req_in    = req_ff;
      rec_in    = rec_ff;
      hit_in    = hit_ff;
      one_in    = one_ff;
      rec_we    = 1'b0;
      rec_waddr = s_ff;
      rec_wdata = rec_ff;
      rec_raddr = s_ff;
      lru_we    = 1'b0;
      lru_waddr = p_ff;
      lru_wdata = s_ff;
      lru_raddr = p_ff;
      emit      = 1'b0;
      emit_word = '0;
      case (state_ff)
         S_CLEAR: begin
            rec_we    = 1'b1;
            rec_waddr = cnt_ff;
            rec_wdata = pack_rec(16'hFFFF, 32'hFFFF_FFFF, ST_INVALID, '0, 1'b0);
            lru_we    = 1'b1;
            lru_waddr = cnt_ff;
            lru_wdata = cnt_ff;
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_word;
               hit_in = 1'b0;
               cnt_in = '0;
               p_in   = '0;
               case (req_word.action)
                  ACT_GET, ACT_READ: state_in = S_LK_RD;
                  ACT_RELEASE, ACT_MARK, ACT_IODONE: begin
                     if (32'(req_word.entry) < ENTRIES) begin
                        s_in     = to_idx(req_word.entry);
                        state_in = S_EN_RD;
                     end else begin
                        one_in   = '{K_ERROR, req_word.entry, 16'd0, 32'd0, 1'b0, 1'b1};
                        state_in = S_ONE;
                     end
                  end
                  ACT_SYNC: state_in = S_WK_RD;
                  default: begin
                     one_in   = '{K_ERROR, 4'd0, 16'd0, 32'd0, 1'b0, 1'b1};
                     state_in = S_ONE;
                  end
               endcase
            end
         end
         S_LK_RD: begin
            rec_raddr = cnt_ff;
            state_in  = S_LK_CMP;
         end
         S_LK_CMP: begin
            // next slot is read while this one compares
            rec_raddr = (cnt_ff == LAST) ? '0 : cnt_ff + IW'(1);
            if (r_dev == req_ff.device && r_blk == req_ff.block) begin
               s_in     = cnt_ff;
               rec_in   = pack_rec(r_dev, r_blk, r_st, inc(r_refs), r_busy);
               hit_in   = 1'b1;
               p_in     = '0;
               state_in = S_PF_RD;
            end else if (cnt_ff == LAST) begin
               p_in     = '0;
               state_in = S_WK_RD;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         S_PF_RD: begin
            lru_raddr = p_ff;
            state_in  = S_PF_CMP;
         end
         S_PF_CMP: begin
            lru_raddr = (p_ff == LAST) ? '0 : p_ff + IW'(1);
            if (lru_rdata == s_ff) begin
               state_in = S_SH_RD;
            end else begin
               p_in = p_ff + IW'(1);
            end
         end
         S_SH_RD: begin
            if (p_ff == LAST) begin
               state_in = S_SH_LAST;
            end else begin
               lru_raddr = p_ff + IW'(1);
               state_in  = S_SH_WR;
            end
         end
         S_SH_WR: begin
            lru_we    = 1'b1;
            lru_waddr = p_ff;
            lru_wdata = lru_rdata;
            p_in      = p_ff + IW'(1);
            state_in  = S_SH_RD;
         end
         S_SH_LAST: begin
            lru_we    = 1'b1;
            lru_waddr = LAST;
            lru_wdata = s_ff;
            state_in  = S_ACQ;
         end
         S_ACQ: begin
            if (out_free) begin
               rec_we    = 1'b1;
               emit      = 1'b1;
               emit_word = '{K_ACQUIRED, to_ent(s_ff), f_dev, f_blk, hit_ff, !needrd};
               if (needrd) begin
                  rec_in   = pack_rec(f_dev, f_blk, f_st, inc(f_refs), 1'b1);
                  state_in = S_RDREQ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RDREQ: begin
            if (out_free) begin
               rec_we    = 1'b1;
               emit      = 1'b1;
               emit_word = '{IO_READ, to_ent(s_ff), f_dev, f_blk, 1'b0, 1'b1};
               state_in  = S_IDLE;
            end
         end
         S_WK_RD: begin
            lru_raddr = p_ff;
            state_in  = S_WK_SLOT;
         end
         S_WK_SLOT: begin
            rec_raddr = lru_rdata;
            s_in      = lru_rdata;
            state_in  = S_WK_EVAL;
         end
         S_WK_EVAL: begin
            if (r_st == ST_DIRTY) begin
               if (!r_busy) begin
                  if (out_free) begin
                     emit      = 1'b1;
                     emit_word = '{K_WRITE, to_ent(s_ff), r_dev, r_blk, 1'b0, 1'b0};
                     rec_we    = 1'b1;
                     rec_wdata = pack_rec(r_dev, r_blk, r_st, inc(r_refs), 1'b1);
                     adv       = 1'b1;
                  end
               end else begin
                  adv = 1'b1;
               end
            end else if (is_sync || r_refs != '0 || r_busy) begin
               adv = 1'b1;
            end else begin
               rec_in   = pack_rec(req_ff.device, req_ff.block, ST_INVALID,
                                   REF_BITS'(1), 1'b0);
               state_in = S_SH_RD;
            end
            if (adv) begin
               if (p_ff == LAST) begin
                  if (is_sync) begin
                     one_in = '{K_DONE, 4'd0, 16'd0, 32'd0, 1'b0, 1'b1};
                  end else begin
                     one_in = '{K_NOFREE, 4'd0, req_ff.device, req_ff.block, 1'b0, 1'b1};
                  end
                  state_in = S_ONE;
               end else begin
                  p_in     = p_ff + IW'(1);
                  state_in = S_WK_RD;
               end
            end
         end
         S_EN_RD: begin
            state_in = S_EN_EVAL;
         end
         S_EN_EVAL: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_word = '{K_DONE, to_ent(s_ff), r_dev, r_blk, 1'b0, 1'b1};
               state_in  = S_IDLE;
               case (req_ff.action)
                  ACT_RELEASE: begin
                     if (r_refs == '0) begin
                        emit_word.kind = K_ERROR;
                     end else begin
                        rec_we    = 1'b1;
                        rec_wdata = pack_rec(r_dev, r_blk, r_st, r_refs - REF_BITS'(1),
                                             r_busy);
                     end
                  end
                  ACT_MARK: begin
                     if (r_st == ST_INVALID) begin
                        emit_word.kind = K_ERROR;
                     end else begin
                        rec_we    = 1'b1;
                        rec_wdata = pack_rec(r_dev, r_blk, ST_DIRTY, r_refs, r_busy);
                     end
                  end
                  default: begin
                     if (req_ff.io_status > ST_DIRTY) begin
                        emit_word.kind = K_ERROR;
                     end else begin
                        rec_we = 1'b1;
                        if (r_refs == '0) begin
                           emit_word.kind = K_ERROR;
                           rec_wdata = pack_rec(r_dev, r_blk, req_ff.io_status, r_refs,
                                                1'b0);
                        end else begin
                           rec_wdata = pack_rec(r_dev, r_blk, req_ff.io_status,
                                                r_refs - REF_BITS'(1), 1'b0);
                        end
                     end
                  end
               endcase
            end
         end
         S_ONE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_word = one_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (emit) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
      p_ff   <= p_in;
      s_ff   <= s_in;
      req_ff <= req_in;
      rec_ff <= rec_in;
      hit_ff <= hit_in;
      one_ff <= one_in;
      if (emit) begin
         rsp_ff <= emit_word;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_ff;

   bbc_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_rec_ram (
      .clock (clock),
      .we    (rec_we),
      .waddr (rec_waddr),
      .wdata (rec_wdata),
      .raddr (rec_raddr),
      .rdata (rec_rdata)
   );

   bbc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_lru_ram (
      .clock (clock),
      .we    (lru_we),
      .waddr (lru_waddr),
      .wdata (lru_wdata),
      .raddr (lru_raddr),
      .rdata (lru_rdata)
   );

endmodule
`default_nettype wire

>>> design/bbc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> design/bbc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_checker
// Port level checks of the buffer cache engine, bound to the top level.
// ----------------------------------------------------------------------------
module bbc_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire bbc_pkg::req_type req_word,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire bbc_pkg::rsp_type rsp_word
);
   import bbc_pkg::*;

   // clearing pass follows reset, nothing is accepted meanwhile
   a_reset_stall: assert property (@(posedge clock) reset |=> req_stall && !rsp_valid)
      else $error("request taken or word shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // a write request is never the closing word of an item
   a_write_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind == K_WRITE |-> !rsp_word.last)
      else $error("write request flagged last");

   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.hit |-> rsp_word.kind == K_ACQUIRED)
      else $error("hit flag on a word other than acquired");

endmodule

bind block_buffer_cache_lru_top bbc_checker u_bbc_checker (.*);
`default_nettype wire
